FILE: src/quaternion_geodesic_midpoint_macros.svh
// Assertion macros shared by the quaternion midpoint checker.
`ifndef QUATERNION_GEODESIC_MIDPOINT_MACROS_SVH
`define QUATERNION_GEODESIC_MIDPOINT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QGM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qgm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qgm assertion failed");

// Next-cycle implication that is checked during reset as well.
`define QGM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("qgm assertion failed");

`endif

FILE: src/qgm_pkg.sv
// Shared types, widths and product tables for the quaternion midpoint pipeline.
`timescale 1ns / 1ps
`default_nettype none
package qgm_pkg;

    localparam int FRAC_BITS = 30;
    localparam int Q_W       = 32;
    localparam int HSUM_W    = 2 * Q_W + 2;
    localparam int P_W       = HSUM_W - FRAC_BITS;
    localparam int T_W       = P_W + 1;
    localparam int N_W       = ((T_W + FRAC_BITS) / 2) * 2;
    localparam int S_W       = N_W / 2;
    localparam int RM_W      = S_W + 2;
    localparam int D_W       = S_W + 1;
    localparam int NUM_W     = P_W + FRAC_BITS;
    localparam int R_W       = 64;
    localparam int HALF_W    = R_W / 2;
    localparam int LO_W      = HALF_W + 1 + Q_W;
    localparam int HI_W      = HALF_W + Q_W;
    localparam int PR_W      = R_W + Q_W;
    localparam int PAIR_W    = PR_W + 1;
    localparam int SUM_W     = PR_W + 2;
    localparam int SH_W      = SUM_W - FRAC_BITS;

    localparam longint ONE_FIX  = 64'sd1 <<< FRAC_BITS;
    localparam longint ANTI_LIM = ONE_FIX - (ONE_FIX + 64'sd999999999) / 64'sd1000000000;

    localparam logic signed [P_W-1:0] ANTI_NEG = P_W'(-ANTI_LIM);
    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Component 0 is the scalar part, then x, y, z.
    typedef logic [3:0][Q_W-1:0] t_quat;
    typedef logic [3:0][P_W-1:0] t_pquat;

    typedef struct packed {
        logic                 anti;
        logic [2:0][P_W-1:0]  pv;
        t_quat                q1;
    } t_side;

    typedef struct packed {
        logic            anti;
        logic [2:0]      neg;
        logic [S_W-1:0]  s;
        t_quat           q1;
    } t_dside;

    // p = q2 * conj(q1): term k of component k/4 is HAM_B-th q2 part times HAM_A-th q1 part.
    localparam int HAM_B [16] = '{0, 1, 2, 3,  0, 1, 2, 3,  0, 2, 3, 1,  0, 3, 1, 2};
    localparam int HAM_A [16] = '{0, 1, 2, 3,  1, 0, 3, 2,  2, 0, 1, 3,  3, 0, 2, 1};
    localparam logic HAM_NEG [16] = '{0, 0, 0, 0,  1, 0, 1, 0,  1, 0, 1, 0,  1, 0, 1, 0};

    // mid = root * q1: term k is MID_R-th root part times MID_A-th q1 part.
    localparam int MID_R [16] = '{0, 1, 2, 3,  0, 1, 2, 3,  0, 2, 3, 1,  0, 3, 1, 2};
    localparam int MID_A [16] = '{0, 1, 2, 3,  1, 0, 3, 2,  2, 0, 1, 3,  3, 0, 2, 1};
    localparam logic MID_NEG [16] = '{0, 1, 1, 1,  0, 0, 0, 1,  0, 0, 0, 1,  0, 0, 0, 1};

endpackage
`default_nettype wire

FILE: src/qgm_hamil.sv
// Hamilton product q2 * conj(q1) in two stages, with the antipodal test.
`timescale 1ns / 1ps
`default_nettype none
module qgm_hamil (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire qgm_pkg::t_quat i_q1,
    input  wire qgm_pkg::t_quat i_q2,
    output logic                o_valid,
    output logic                o_anti,
    output qgm_pkg::t_quat      o_q1,
    output qgm_pkg::t_pquat     o_p
);
    logic signed [2*qgm_pkg::Q_W-1:0]  r_prod [16];
    logic                              r_v1;
    qgm_pkg::t_quat                    r_q1a;
    logic                              r_v2;
    qgm_pkg::t_quat                    r_q1b;
    qgm_pkg::t_pquat                   r_p;
    logic                              r_anti;
    logic signed [qgm_pkg::HSUM_W-1:0] n_acc [4];
    qgm_pkg::t_pquat                   n_p;
    logic                              n_anti;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 16; k++) begin
                r_prod[k] <= $signed(i_q2[qgm_pkg::HAM_B[k]]) *
                             $signed(i_q1[qgm_pkg::HAM_A[k]]);
            end
            r_q1a <= i_q1;
        end
    end

    always_comb begin
        for (int o = 0; o < 4; o++) begin
            n_acc[o] = '0;
            for (int t = 0; t < 4; t++) begin
                if (qgm_pkg::HAM_NEG[4*o+t]) begin
                    n_acc[o] = n_acc[o] - qgm_pkg::HSUM_W'(r_prod[4*o+t]);
                end else begin
                    n_acc[o] = n_acc[o] + qgm_pkg::HSUM_W'(r_prod[4*o+t]);
                end
            end
            n_p[o] = n_acc[o][qgm_pkg::HSUM_W-1:qgm_pkg::FRAC_BITS];
        end
        n_anti = $signed(n_p[0]) < qgm_pkg::ANTI_NEG;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_anti <= n_anti;
            r_q1b  <= r_q1a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_anti  = r_anti;
    assign o_q1    = r_q1b;
    assign o_p     = r_p;
endmodule
`default_nettype wire

FILE: src/qgm_sqrt.sv
// Pipelined integer square root of (1 + p0) / 2, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qgm_sqrt (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic            i_anti,
    input  wire qgm_pkg::t_pquat i_p,
    input  wire qgm_pkg::t_quat  i_q1,
    output logic                 o_valid,
    output logic [qgm_pkg::S_W-1:0] o_s,
    output qgm_pkg::t_side       o_side
);
    localparam int S_W  = qgm_pkg::S_W;
    localparam int N_W  = qgm_pkg::N_W;
    localparam int RM_W = qgm_pkg::RM_W;
    localparam int T_W  = qgm_pkg::T_W;

    logic [N_W-1:0]  r_rad  [S_W];
    logic [RM_W-1:0] r_rem  [S_W];
    logic [S_W-1:0]  r_root [S_W];
    logic            r_vld  [S_W];
    qgm_pkg::t_side  r_side [S_W];

    logic [T_W-1:0]  in_t;
    logic [N_W-1:0]  in_rad;
    qgm_pkg::t_side  in_side;

    // The radicand is (2^F + p0) * 2^(F-1); the antipodal case needs no root.
    assign in_t   = {i_p[0][qgm_pkg::P_W-1], i_p[0]} + T_W'(qgm_pkg::ONE_FIX);
    assign in_rad = i_anti ? '0 : (N_W'(in_t) << (qgm_pkg::FRAC_BITS - 1));
    assign in_side.anti = i_anti;
    assign in_side.pv   = {i_p[3], i_p[2], i_p[1]};
    assign in_side.q1   = i_q1;

    for (genvar g = 0; g < S_W; g++) begin : g_stage
        logic [N_W-1:0]  prv_rad;
        logic [RM_W-1:0] prv_rem;
        logic [S_W-1:0]  prv_root;
        logic            prv_vld;
        qgm_pkg::t_side  prv_side;
        logic [RM_W-1:0] rem_sh;
        logic [RM_W-1:0] trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign prv_rad  = in_rad;
            assign prv_rem  = '0;
            assign prv_root = '0;
            assign prv_vld  = i_valid;
            assign prv_side = in_side;
        end else begin : g_next
            assign prv_rad  = r_rad[g-1];
            assign prv_rem  = r_rem[g-1];
            assign prv_root = r_root[g-1];
            assign prv_vld  = r_vld[g-1];
            assign prv_side = r_side[g-1];
        end

        assign rem_sh = {prv_rem[RM_W-3:0], prv_rad[N_W-1 -: 2]};
        assign trial  = {prv_root, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g]  <= prv_rad << 2;
                r_rem[g]  <= ge ? rem_sh - trial : rem_sh;
                r_root[g] <= {prv_root[S_W-2:0], ge};
                r_side[g] <= prv_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= prv_vld;
            end
        end
    end

    assign o_valid = r_vld[S_W-1];
    assign o_s     = r_root[S_W-1];
    assign o_side  = r_side[S_W-1];
endmodule
`default_nettype wire

FILE: src/qgm_div.sv
// Three-lane pipelined restoring divider: |p_k| * 2^F / (2 s), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qgm_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [qgm_pkg::S_W-1:0] i_s,
    input  wire qgm_pkg::t_side     i_side,
    output logic                    o_valid,
    output logic [2:0][qgm_pkg::R_W-1:0] o_quo,
    output qgm_pkg::t_dside         o_ds
);
    localparam int NUM_W = qgm_pkg::NUM_W;
    localparam int D_W   = qgm_pkg::D_W;
    localparam int R_W   = qgm_pkg::R_W;
    localparam int P_W   = qgm_pkg::P_W;

    logic [2:0][NUM_W-1:0] r_num [NUM_W];
    logic [2:0][D_W-1:0]   r_rem [NUM_W];
    logic [2:0][R_W-1:0]   r_quo [NUM_W];
    logic                  r_vld [NUM_W];
    qgm_pkg::t_dside       r_ds  [NUM_W];

    logic [2:0][NUM_W-1:0] in_num;
    qgm_pkg::t_dside       in_ds;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_ds.neg[k] = i_side.pv[k][P_W-1];
            in_num[k]    = {(in_ds.neg[k] ? P_W'(-$signed(i_side.pv[k])) : i_side.pv[k]),
                            {qgm_pkg::FRAC_BITS{1'b0}}};
        end
        in_ds.anti = i_side.anti;
        in_ds.s    = i_s;
        in_ds.q1   = i_side.q1;
    end

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [2:0][NUM_W-1:0] prv_num;
        logic [2:0][D_W-1:0]   prv_rem;
        logic [2:0][R_W-1:0]   prv_quo;
        logic                  prv_vld;
        qgm_pkg::t_dside       prv_ds;
        logic [D_W:0]          dvs;
        logic [2:0][D_W:0]     rem_sh;
        logic [2:0][D_W:0]     rem_sub;
        logic [2:0]            ge;

        if (g == 0) begin : g_first
            assign prv_num = in_num;
            assign prv_rem = '0;
            assign prv_quo = '0;
            assign prv_vld = i_valid;
            assign prv_ds  = in_ds;
        end else begin : g_next
            assign prv_num = r_num[g-1];
            assign prv_rem = r_rem[g-1];
            assign prv_quo = r_quo[g-1];
            assign prv_vld = r_vld[g-1];
            assign prv_ds  = r_ds[g-1];
        end

        assign dvs = {1'b0, prv_ds.s, 1'b0};

        for (genvar k = 0; k < 3; k++) begin : g_lane
            assign rem_sh[k]  = {prv_rem[k], prv_num[k][NUM_W-1]};
            assign ge[k]      = rem_sh[k] >= dvs;
            assign rem_sub[k] = rem_sh[k] - dvs;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_num[g][k] <= prv_num[k] << 1;
                    r_rem[g][k] <= ge[k] ? rem_sub[k][D_W-1:0] : rem_sh[k][D_W-1:0];
                    r_quo[g][k] <= {prv_quo[k][R_W-2:0], ge[k]};
                end
                r_ds[g] <= prv_ds;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= prv_vld;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_ds    = r_ds[NUM_W-1];
endmodule
`default_nettype wire

FILE: src/qgm_mid.sv
// Root assembly, Hamilton product root * q1 and saturation, ending in the output register.
`timescale 1ns / 1ps
`default_nettype none
module qgm_mid (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire logic [2:0][qgm_pkg::R_W-1:0] i_quo,
    input  wire qgm_pkg::t_dside         i_ds,
    output logic                         o_valid,
    output qgm_pkg::t_quat               o_mid
);
    localparam int R_W    = qgm_pkg::R_W;
    localparam int HALF_W = qgm_pkg::HALF_W;
    localparam int PR_W   = qgm_pkg::PR_W;
    localparam int PAIR_W = qgm_pkg::PAIR_W;
    localparam int SUM_W  = qgm_pkg::SUM_W;
    localparam int SH_W   = qgm_pkg::SH_W;
    localparam int Q_W    = qgm_pkg::Q_W;

    logic [3:0][R_W-1:0]              r_root;
    qgm_pkg::t_quat                   r_q1;
    logic signed [qgm_pkg::LO_W-1:0]  r_lo   [16];
    logic signed [qgm_pkg::HI_W-1:0]  r_hi   [16];
    logic signed [PR_W-1:0]           r_prod [16];
    logic signed [PAIR_W-1:0]         r_pair [8];
    qgm_pkg::t_quat                   r_mid;
    logic [4:0]                       r_vld;

    logic [3:0][R_W-1:0]              n_root;
    logic signed [PAIR_W-1:0]         n_term [16];
    logic signed [SUM_W-1:0]          n_sum  [4];
    logic [SH_W-1:0]                  n_sh   [4];
    qgm_pkg::t_quat                   n_mid;

    // Antipodal pairs rotate half a turn about z: root = (0, 0, 0, 1).
    always_comb begin
        n_root[0] = i_ds.anti ? '0 : R_W'(i_ds.s);
        for (int k = 0; k < 3; k++) begin
            if (i_ds.anti) begin
                n_root[k+1] = (k == 2) ? R_W'(qgm_pkg::ONE_FIX) : '0;
            end else begin
                n_root[k+1] = i_ds.neg[k] ? -i_quo[k] : i_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
            r_q1   <= i_ds.q1;
        end
    end

    // Each 64 x 32 product is split into two partial products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 16; k++) begin
                r_lo[k] <= $signed({1'b0, r_root[qgm_pkg::MID_R[k]][HALF_W-1:0]}) *
                           $signed(r_q1[qgm_pkg::MID_A[k]]);
                r_hi[k] <= $signed(r_root[qgm_pkg::MID_R[k]][R_W-1:HALF_W]) *
                           $signed(r_q1[qgm_pkg::MID_A[k]]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 16; k++) begin
                r_prod[k] <= $signed({r_hi[k], {HALF_W{1'b0}}}) + PR_W'(r_lo[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            n_term[k] = qgm_pkg::MID_NEG[k] ? -PAIR_W'(r_prod[k]) : PAIR_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 8; j++) begin
                r_pair[j] <= n_term[2*j] + n_term[2*j+1];
            end
        end
    end

    always_comb begin
        for (int o = 0; o < 4; o++) begin
            n_sum[o] = SUM_W'(r_pair[2*o]) + SUM_W'(r_pair[2*o+1]);
            n_sh[o]  = n_sum[o][SUM_W-1:qgm_pkg::FRAC_BITS];
            if ((&n_sh[o][SH_W-1:Q_W-1]) || !(|n_sh[o][SH_W-1:Q_W-1])) begin
                n_mid[o] = n_sh[o][Q_W-1:0];
            end else begin
                n_mid[o] = n_sh[o][SH_W-1] ? qgm_pkg::Q_MIN : qgm_pkg::Q_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    assign o_valid = r_vld[4];
    assign o_mid   = r_mid;
endmodule
`default_nettype wire

FILE: src/quaternion_geodesic_midpoint.sv
// Top level of the quaternion geodesic midpoint pipeline.
// Usage:
// The slave channel takes one item per accepted beat: two quaternions q1 and q2,
// each as four Q2.30 components. The master channel returns one item per input:
// the point halfway along the great arc from q1 to q2, each component saturated.
// The block computes p = q2 * conj(q1), takes its square root as a rotation
// (the half-turn about z when p is nearly -1) and returns root * q1.
// From acceptance to o_m_tvalid an item passes the Hamilton product, the square
// root (one result bit per stage), the three-lane divider (one quotient bit per
// stage) and the final product and saturation.
// Throughput is one item per cycle while the pipeline is not stalled; every stage
// is a register and a new item may enter in each cycle that the pipeline advances.
// The whole pipeline advances on one enable that is high while the output register
// is empty or being taken. When the receiver stalls with a result waiting, every
// stage holds and o_s_tready drops; nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_geodesic_midpoint (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z
    input  wire logic [255:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // mid_w, mid_x, mid_y, mid_z
    output logic [127:0]      o_m_tdata
);
    logic                                en;
    logic                                ham_valid;
    logic                                ham_anti;
    qgm_pkg::t_quat                      ham_q1;
    qgm_pkg::t_pquat                     ham_p;
    logic                                sq_valid;
    logic [qgm_pkg::S_W-1:0]             sq_s;
    qgm_pkg::t_side                      sq_side;
    logic                                dv_valid;
    logic [2:0][qgm_pkg::R_W-1:0]        dv_quo;
    qgm_pkg::t_dside                     dv_ds;
    logic                                mid_valid;
    qgm_pkg::t_quat                      mid_q;

    // Global stall: the pipeline moves when the output register can take a result.
    assign en         = !mid_valid || i_m_tready;
    assign o_s_tready = en;

    qgm_hamil u_hamil (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_q1    (i_s_tdata[127:0]),
        .i_q2    (i_s_tdata[255:128]),
        .o_valid (ham_valid),
        .o_anti  (ham_anti),
        .o_q1    (ham_q1),
        .o_p     (ham_p)
    );

    qgm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ham_valid),
        .i_anti  (ham_anti),
        .i_p     (ham_p),
        .i_q1    (ham_q1),
        .o_valid (sq_valid),
        .o_s     (sq_s),
        .o_side  (sq_side)
    );

    qgm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_s     (sq_s),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_ds    (dv_ds)
    );

    qgm_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_quo   (dv_quo),
        .i_ds    (dv_ds),
        .o_valid (mid_valid),
        .o_mid   (mid_q)
    );

    assign o_m_tvalid = mid_valid;
    assign o_m_tdata  = mid_q;
endmodule
`default_nettype wire

FILE: src/qgm_checker.sv
// Port-level checker for the quaternion midpoint block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_geodesic_midpoint_macros.svh"
module qgm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [127:0] o_m_tdata
);
    // A waiting result holds until taken.
    `QGM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `QGM_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))
    // The pipeline stalls as a whole while a result waits.
    `QGM_ASSERT_IMPL(a_stall_in, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready)
    // Reset empties the pipeline.
    `QGM_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid)
endmodule

bind quaternion_geodesic_midpoint qgm_checker u_qgm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

FILE: verif/quaternion_geodesic_midpoint_test.sv
// Self-checking testbench for the quaternion geodesic midpoint pipeline.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_geodesic_midpoint_test;

    localparam int RANDOM_PAIRS = 450;
    localparam int DRAIN_CYCLES = 150;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [255:0] pair;
        bit           known;
        logic [127:0] mid;
    } t_row;

    typedef struct {
        logic [127:0] mid;
        bit           known;
        logic [127:0] typed_mid;
    } t_midpoint_due;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [255:0] i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [127:0] o_m_tdata;

    t_midpoint_due midpoints_due[$];
    t_row          rows[$];
    int            row_of_next_accept = 0;
    int            directed_count = 0;
    bit            calm = 1'b0;
    bit            failed = 1'b0;

    quaternion_geodesic_midpoint dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        // mid_w, mid_x, mid_y, mid_z
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] saturate(t_wide v);
        if (v > t_wide'(32'sh7fffffff)) return qgm_pkg::Q_MAX;
        if (v < -t_wide'(64'sh80000000)) return qgm_pkg::Q_MIN;
        return v[31:0];
    endfunction

    // Midpoint of the great arc from q1 to q2, with the block's rounding:
    // floor after each product sum, floor square root, divide toward zero.
    function automatic logic [127:0] geodesic_midpoint(logic [255:0] pair);
        t_wide a[4], b[4], p[4], r[4], n, s, c;
        logic [127:0] mid;
        for (int k = 0; k < 4; k++) begin
            a[k] = $signed(pair[32*k +: 32]);
            b[k] = $signed(pair[128 + 32*k +: 32]);
        end
        // p = q2 * conj(q1)
        p[0] = (b[0]*a[0] + b[1]*a[1] + b[2]*a[2] + b[3]*a[3]) >>> qgm_pkg::FRAC_BITS;
        p[1] = (-b[0]*a[1] + a[0]*b[1] - b[2]*a[3] + b[3]*a[2]) >>> qgm_pkg::FRAC_BITS;
        p[2] = (-b[0]*a[2] + a[0]*b[2] - b[3]*a[1] + b[1]*a[3]) >>> qgm_pkg::FRAC_BITS;
        p[3] = (-b[0]*a[3] + a[0]*b[3] - b[1]*a[2] + b[2]*a[1]) >>> qgm_pkg::FRAC_BITS;
        if (p[0] < -t_wide'(qgm_pkg::ANTI_LIM)) begin
            // Nearly opposite rotations: take the half-turn about z.
            r[0] = 0; r[1] = 0; r[2] = 0; r[3] = t_wide'(qgm_pkg::ONE_FIX);
        end else begin
            n = (t_wide'(qgm_pkg::ONE_FIX) + p[0]) <<< (qgm_pkg::FRAC_BITS - 1);
            s = 0;
            for (int bitpos = 47; bitpos >= 0; bitpos--) begin
                c = s | (t_wide'(1) <<< bitpos);
                if (c * c <= n) s = c;
            end
            r[0] = s;
            for (int k = 1; k < 4; k++) r[k] = (p[k] <<< qgm_pkg::FRAC_BITS) / (2 * s);
        end
        // mid = root * q1
        mid[31:0]   = saturate((r[0]*a[0] - r[1]*a[1] - r[2]*a[2] - r[3]*a[3])
                               >>> qgm_pkg::FRAC_BITS);
        mid[63:32]  = saturate((r[0]*a[1] + a[0]*r[1] + r[2]*a[3] - r[3]*a[2])
                               >>> qgm_pkg::FRAC_BITS);
        mid[95:64]  = saturate((r[0]*a[2] + a[0]*r[2] + r[3]*a[1] - r[1]*a[3])
                               >>> qgm_pkg::FRAC_BITS);
        mid[127:96] = saturate((r[0]*a[3] + a[0]*r[3] + r[1]*a[2] - r[2]*a[1])
                               >>> qgm_pkg::FRAC_BITS);
        return mid;
    endfunction

    function automatic logic [255:0] pack_pair(logic [31:0] aw, logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] az, logic [31:0] bw, logic [31:0] bx,
                                               logic [31:0] by, logic [31:0] bz);
        return {bz, by, bx, bw, az, ay, ax, aw};
    endfunction

    function automatic void compare_mid(logic [127:0] want, logic [127:0] got);
        string names[4] = '{"mid_w", "mid_x", "mid_y", "mid_z"};
        for (int k = 0; k < 4; k++) begin
            if (want[32*k +: 32] !== got[32*k +: 32]) begin
                $error("%s: expected %0d, got %0d", names[k],
                       $signed(want[32*k +: 32]), $signed(got[32*k +: 32]));
                failed = 1'b1;
            end
        end
    endfunction

    // Record the expected midpoint of every item the block takes.
    always @(posedge i_clk) begin
        t_midpoint_due due;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            due.mid = geodesic_midpoint(i_s_tdata);
            due.known = 1'b0;
            due.typed_mid = '0;
            if (row_of_next_accept < directed_count) begin
                due.known = rows[row_of_next_accept].known;
                due.typed_mid = rows[row_of_next_accept].mid;
            end
            row_of_next_accept++;
            midpoints_due.push_back(due);
        end
    end

    // Check every midpoint the block hands over against the oldest one due.
    always @(posedge i_clk) begin
        t_midpoint_due due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (midpoints_due.size() == 0) begin
                $error("midpoint item with nothing due: %h", o_m_tdata);
                failed = 1'b1;
            end else begin
                due = midpoints_due.pop_front();
                compare_mid(due.mid, o_m_tdata);
                if (due.known) compare_mid(due.typed_mid, o_m_tdata);
            end
        end
    end

    // Receiver stalls at random except during the calm stretch.
    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 17);
    end

    task automatic send_pair(logic [255:0] pair);
        while (!calm && $urandom_range(99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pair;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [31:0] near_unit_part();
        return 32'($signed($urandom_range(32'h7fffffff, 0)) % (1 << 30) *
                   ($urandom_range(1) ? 1 : -1));
    endfunction

    function automatic logic [255:0] random_pair();
        logic [31:0] q[8];
        int mode = $urandom_range(99);
        for (int k = 0; k < 8; k++) q[k] = near_unit_part();
        if (mode < 20) begin
            // Arbitrary bit patterns over the whole range.
            for (int k = 0; k < 8; k++) q[k] = $urandom();
        end else if (mode < 35) begin
            // q2 close to q1: a short arc.
            for (int k = 0; k < 4; k++) q[4 + k] = q[k] + 32'($urandom_range(2000)) - 32'd1000;
        end else if (mode < 50) begin
            // q2 close to -q1: near or at the antipodal cut.
            for (int k = 0; k < 4; k++) q[4 + k] = -q[k] + 32'($urandom_range(6)) - 32'd3;
        end else if (mode < 60) begin
            // A pure scalar pair around the antipodal threshold.
            q[0] = 32'sd1 <<< qgm_pkg::FRAC_BITS;
            q[1] = '0; q[2] = '0; q[3] = '0;
            q[4] = 32'(-qgm_pkg::ANTI_LIM) + 32'($urandom_range(4)) - 32'd2;
            q[5] = '0; q[6] = '0; q[7] = '0;
        end
        return pack_pair(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
    endfunction

    initial begin
        logic [31:0] one;
        logic [31:0] zero;
        one = 32'sd1 <<< qgm_pkg::FRAC_BITS;
        zero = '0;
        // Directed rows; expected midpoints are typed in only where obvious.
        rows = '{
            '{pack_pair(one, zero, zero, zero, one, zero, zero, zero), 1'b1,
              {zero, zero, zero, one}},
            '{pack_pair(one, zero, zero, zero, -one, zero, zero, zero), 1'b1,
              {one, zero, zero, zero}},
            '{'0, 1'b1, '0},
            '{{8{qgm_pkg::Q_MAX}}, 1'b0, '0},
            '{{8{qgm_pkg::Q_MIN}}, 1'b0, '0},
            '{{{4{qgm_pkg::Q_MIN}}, {4{qgm_pkg::Q_MAX}}}, 1'b0, '0},
            '{{{4{qgm_pkg::Q_MAX}}, {4{qgm_pkg::Q_MIN}}}, 1'b0, '0},
            '{pack_pair(one, zero, zero, zero, 32'(-qgm_pkg::ANTI_LIM), zero, zero, zero),
              1'b0, '0},
            '{pack_pair(one, zero, zero, zero, 32'(-qgm_pkg::ANTI_LIM - 1), zero, zero, zero),
              1'b1, {one, zero, zero, zero}},
            '{pack_pair(one, zero, zero, zero, zero, one, zero, zero), 1'b0, '0},
            '{pack_pair(zero, zero, one, zero, zero, zero, zero, one), 1'b0, '0},
            '{pack_pair(zero, one, zero, zero, zero, -one, zero, zero), 1'b0, '0},
            '{pack_pair(qgm_pkg::Q_MAX, qgm_pkg::Q_MIN, qgm_pkg::Q_MAX, qgm_pkg::Q_MIN,
                        qgm_pkg::Q_MIN, qgm_pkg::Q_MAX, qgm_pkg::Q_MIN, qgm_pkg::Q_MAX),
              1'b0, '0},
            '{pack_pair(32'h5a827999, zero, zero, 32'h5a827999, one, zero, zero, zero),
              1'b0, '0}
        };
        directed_count = rows.size();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_pair(rows[i].pair);
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            calm = (i >= 200 && i < 300);
            send_pair(random_pair());
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;
        while (midpoints_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("quaternion_geodesic_midpoint_test: done, clean");
        end else begin
            $display("quaternion_geodesic_midpoint_test: done, errors");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #2000000;
        $display("quaternion_geodesic_midpoint_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/qgm_pkg.sv
src/qgm_hamil.sv
src/qgm_sqrt.sv
src/qgm_div.sv
src/qgm_mid.sv
src/quaternion_geodesic_midpoint.sv
src/qgm_checker.sv
verif/quaternion_geodesic_midpoint_test.sv
